FILE: sv/rcwu_pkg.sv
package rcwu_pkg;

   // Default values for the top level parameters
   localparam int INIT_WINDOW_DEFAULT = 10;
   localparam int WINDOW_BITS_DEFAULT = 16;

   // Fixed field widths
   localparam int FIELD_W       = 16;
   localparam int FLOOR_W       = 15;
   localparam int TSO_DIV_W     = 8;
   localparam int GSO_SIZE_W    = 17;
   localparam int DEFER_W       = 8;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 17;

   // Divider retires this many quotient bits per cycle
   localparam int DIV_BITS_PER_CYCLE = 4;

   // Smallest threshold stored on a loss event
   localparam int MIN_THRESHOLD = 2;

   // Request actions
   localparam logic ACTION_ACK  = 1'b0;
   localparam logic ACTION_LOSS = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SS_LIMIT          = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TSO_WIN_DIVISOR   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GSO_ENABLED       = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GSO_MAX_SIZE      = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GSO_MAX_SEGS      = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_SIZE      = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_CLAMP      = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFERRED_SEGMENTS = 4'd7;

   // Register reset values
   localparam logic [FIELD_W-1:0]    SS_LIMIT_RESET          = 16'd0;
   localparam logic [TSO_DIV_W-1:0]  TSO_WIN_DIVISOR_RESET   = 8'd3;
   localparam logic                  GSO_ENABLED_RESET       = 1'b1;
   localparam logic [GSO_SIZE_W-1:0] GSO_MAX_SIZE_RESET      = 17'd65536;
   localparam logic [FIELD_W-1:0]    GSO_MAX_SEGS_RESET      = 16'd65535;
   localparam logic [FIELD_W-1:0]    SEGMENT_SIZE_RESET      = 16'd1460;
   localparam logic [FIELD_W-1:0]    WINDOW_CLAMP_RESET      = 16'd65535;
   localparam logic [DEFER_W-1:0]    DEFERRED_SEGMENTS_RESET = 8'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_DIVIDE,
      ST_COMMIT
   } rcwu_state_type;

   typedef struct packed {
      logic capture;
      logic check;
      logic decide;
      logic div_start;
      logic commit;
   } rcwu_cmd_type;

   typedef struct packed {
      logic is_loss;
      logic limited;
      logic exp_growth;
      logic div_done;
      logic out_free;
   } rcwu_status_type;

endpackage

FILE: sv/reno_congestion_window_update_unit.sv
// Reno congestion window engine for one connection. Each request is an ack
// (grow the window if it is the limit, by slow start or additive increase,
// capped by window_clamp) or a loss (ssthresh = max(cwnd/2, 2)), and yields one
// response with the window, ssthresh, the limited flag and ssthresh/2. A loss,
// an ack that finds the window not limiting and an additive-increase ack pass
// through capture, offload products, decision and commit to the response
// register. A slow start ack also runs the window division through a
// restoring divider that retires 4 quotient bits a cycle, between decision
// and commit. One request is in work at a time; the next is taken the cycle
// after commit while the response may still wait in its output register.
// Registers may be written at any time the block is idle; csr_ready is always
// high.
module reno_congestion_window_update_unit import rcwu_pkg::*; #(
   parameter int INIT_WINDOW = INIT_WINDOW_DEFAULT,
   parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [FIELD_W-1:0]     req_packets_in_flight,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FIELD_W-1:0]     rsp_window,
   output logic [FIELD_W-1:0]     rsp_threshold,
   output logic                   rsp_window_limited,
   output logic [FLOOR_W-1:0]     rsp_floor_window
);

   rcwu_cmd_type    cmd;
   rcwu_status_type status;

   rcwu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   rcwu_dpath #(
      .INIT_WINDOW(INIT_WINDOW),
      .WINDOW_BITS(WINDOW_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_action           (req_action),
      .req_packets_in_flight(req_packets_in_flight),
      .cmd                  (cmd),
      .status               (status),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_window           (rsp_window),
      .rsp_threshold        (rsp_threshold),
      .rsp_window_limited   (rsp_window_limited),
      .rsp_floor_window     (rsp_floor_window)
   );

endmodule

FILE: sv/rcwu_div.sv
module rcwu_div import rcwu_pkg::*; #(
   parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT,
   parameter int DIVIDEND_BITS = WINDOW_BITS_DEFAULT + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [WINDOW_BITS-1:0]   divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic [WINDOW_BITS-1:0]   remainder
);

   localparam int W    = WINDOW_BITS;
   localparam int NDIG = (DIVIDEND_BITS + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
   localparam int SHW  = NDIG * DIV_BITS_PER_CYCLE;
   localparam int CNTW = $clog2(NDIG + 1);

   logic [SHW-1:0]  shift_ff, shift_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    divisor_ff, divisor_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;

   logic [SHW-1:0]  step_sh;
   logic [W-1:0]    step_rem;
   logic [W:0]      step_trial;

   // Retire one digit: DIV_BITS_PER_CYCLE restoring subtract steps
   always_comb begin
      step_sh    = shift_ff;
      step_rem   = rem_ff;
      step_trial = '0;
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         step_trial = {step_rem, step_sh[SHW-1]};
         step_sh    = {step_sh[SHW-2:0], 1'b0};
         if (step_trial >= {1'b0, divisor_ff}) begin
            step_trial = step_trial - {1'b0, divisor_ff};
            step_sh[0] = 1'b1;
         end
         step_rem = step_trial[W-1:0];
      end
   end

   // Load on start, advance while busy
   always_comb begin
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         shift_in   = SHW'(dividend);
         rem_in     = '0;
         divisor_in = divisor;
         cnt_in     = CNTW'(NDIG);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         shift_in = step_sh;
         rem_in   = step_rem;
         cnt_in   = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = shift_ff[DIVIDEND_BITS-1:0];
   assign remainder = rem_ff;

endmodule

FILE: sv/rcwu_ctrl.sv
module rcwu_ctrl import rcwu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rcwu_status_type status,
   output rcwu_cmd_type    cmd
);

   rcwu_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!status.is_loss && status.limited && status.exp_growth) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide    = 1'b1;
            cmd.div_start = !status.is_loss && status.limited && status.exp_growth;
         end
         ST_DIVIDE: begin
            cmd = '0;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/rcwu_dpath.sv
module rcwu_dpath import rcwu_pkg::*; #(
   parameter int INIT_WINDOW = INIT_WINDOW_DEFAULT,
   parameter int WINDOW_BITS = WINDOW_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_action,
   input  logic [FIELD_W-1:0]     req_packets_in_flight,
   input  rcwu_cmd_type           cmd,
   output rcwu_status_type        status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [FIELD_W-1:0]     rsp_window,
   output logic [FIELD_W-1:0]     rsp_threshold,
   output logic                   rsp_window_limited,
   output logic [FLOOR_W-1:0]     rsp_floor_window
);

   localparam int W   = WINDOW_BITS;
   localparam int AW  = (W > FIELD_W) ? W : FIELD_W;
   localparam int DW  = AW + 1;
   localparam int GW  = AW + 2;
   localparam int TPW = AW + TSO_DIV_W;
   localparam int SPW = AW + FIELD_W;

   // Configuration registers
   logic [FIELD_W-1:0]    ss_limit_ff, ss_limit_in;
   logic [TSO_DIV_W-1:0]  tso_win_divisor_ff, tso_win_divisor_in;
   logic                  gso_enabled_ff, gso_enabled_in;
   logic [GSO_SIZE_W-1:0] gso_max_size_ff, gso_max_size_in;
   logic [FIELD_W-1:0]    gso_max_segs_ff, gso_max_segs_in;
   logic [FIELD_W-1:0]    segment_size_ff, segment_size_in;
   logic [FIELD_W-1:0]    window_clamp_ff, window_clamp_in;
   logic [DEFER_W-1:0]    deferred_segments_ff, deferred_segments_in;

   // Connection state
   logic [W-1:0] cwnd_ff, cwnd_in;
   logic [W-1:0] ssthresh_ff, ssthresh_in;
   logic [W-1:0] ack_count_ff, ack_count_in;

   // Per-request working registers
   logic           action_ff, action_in;
   logic           flight_ge_ff, flight_ge_in;
   logic [AW-1:0]  left_ff, left_in;
   logic [TPW-1:0] tso_prod_ff, tso_prod_in;
   logic [SPW-1:0] seg_prod_ff, seg_prod_in;
   logic           limited_ff, limited_in;
   logic           slow_ff, slow_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_window_ff, rsp_window_in;
   logic [FIELD_W-1:0] rsp_threshold_ff, rsp_threshold_in;
   logic               rsp_limited_ff, rsp_limited_in;
   logic [FLOOR_W-1:0] rsp_floor_ff, rsp_floor_in;

   logic [AW-1:0]  cwnd_ext;
   logic [AW-1:0]  clamp_ext;
   logic [W-1:0]   base;
   logic [AW-1:0]  inc;
   logic [DW-1:0]  dividend;
   logic           limited_now;
   logic           slow_now;
   logic           div_done;
   logic [DW-1:0]  quotient;
   logic [W-1:0]   remainder;
   logic [GW-1:0]  grown;
   logic [W-1:0]   ss_cwnd;
   logic [W-1:0]   half;
   logic [W-1:0]   loss_thresh;
   logic [AW-1:0]  cwnd_out_ext;
   logic [AW-1:0]  ssthresh_out_ext;

   assign csr_ready = 1'b1;

   // Register writes, unknown indexes dropped
   always_comb begin
      ss_limit_in          = ss_limit_ff;
      tso_win_divisor_in   = tso_win_divisor_ff;
      gso_enabled_in       = gso_enabled_ff;
      gso_max_size_in      = gso_max_size_ff;
      gso_max_segs_in      = gso_max_segs_ff;
      segment_size_in      = segment_size_ff;
      window_clamp_in      = window_clamp_ff;
      deferred_segments_in = deferred_segments_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SS_LIMIT:          ss_limit_in          = csr_wdata[FIELD_W-1:0];
            CSR_TSO_WIN_DIVISOR:   tso_win_divisor_in   = csr_wdata[TSO_DIV_W-1:0];
            CSR_GSO_ENABLED:       gso_enabled_in       = csr_wdata[0];
            CSR_GSO_MAX_SIZE:      gso_max_size_in      = csr_wdata[GSO_SIZE_W-1:0];
            CSR_GSO_MAX_SEGS:      gso_max_segs_in      = csr_wdata[FIELD_W-1:0];
            CSR_SEGMENT_SIZE:      segment_size_in      = csr_wdata[FIELD_W-1:0];
            CSR_WINDOW_CLAMP:      window_clamp_in      = csr_wdata[FIELD_W-1:0];
            CSR_DEFERRED_SEGMENTS: deferred_segments_in = csr_wdata[DEFER_W-1:0];
            default: begin
               ss_limit_in = ss_limit_ff;
            end
         endcase
      end
   end

   assign cwnd_ext  = AW'(cwnd_ff);
   assign clamp_ext = AW'(window_clamp_ff);

   // Capture the request and the free window
   assign action_in    = cmd.capture ? req_action : action_ff;
   assign flight_ge_in = cmd.capture ? (AW'(req_packets_in_flight) >= cwnd_ext) : flight_ge_ff;
   assign left_in      = cmd.capture ? (cwnd_ext - AW'(req_packets_in_flight)) : left_ff;

   // Offload deferral products
   assign tso_prod_in = cmd.check ? (TPW'(left_ff) * TPW'(tso_win_divisor_ff)) : tso_prod_ff;
   assign seg_prod_in = cmd.check ? (SPW'(left_ff) * SPW'(segment_size_ff)) : seg_prod_ff;

   // Window-limited test and growth mode
   assign limited_now = flight_ge_ff
      || (gso_enabled_ff
          && (tso_prod_ff < TPW'(cwnd_ext))
          && (seg_prod_ff < SPW'(gso_max_size_ff))
          && (left_ff < AW'(gso_max_segs_ff)))
      || (left_ff <= AW'(deferred_segments_ff));
   assign slow_now   = (cwnd_ff <= ssthresh_ff);
   assign limited_in = cmd.decide ? limited_now : limited_ff;
   assign slow_in    = cmd.decide ? slow_now : slow_ff;

   // Slow start increment and divider operands
   assign base = (cwnd_ff == '0) ? W'(1) : cwnd_ff;
   always_comb begin
      if ((ss_limit_ff != '0) && (cwnd_ext > AW'(ss_limit_ff))) begin
         inc = AW'(ss_limit_ff >> 1);
      end else begin
         inc = AW'(base);
      end
   end
   assign dividend = DW'(ack_count_ff) + DW'(inc);

   rcwu_div #(
      .WINDOW_BITS  (W),
      .DIVIDEND_BITS(DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (base),
      .done     (div_done),
      .quotient (quotient),
      .remainder(remainder)
   );

   // Candidate updates
   assign grown       = GW'(base) + GW'(quotient);
   assign ss_cwnd     = (grown < GW'(clamp_ext)) ? W'(grown) : W'(window_clamp_ff);
   assign half        = cwnd_ff >> 1;
   assign loss_thresh = (half > W'(MIN_THRESHOLD)) ? half : W'(MIN_THRESHOLD);

   // Apply the event on commit
   always_comb begin
      cwnd_in      = cwnd_ff;
      ssthresh_in  = ssthresh_ff;
      ack_count_in = ack_count_ff;
      if (cmd.commit) begin
         if (action_ff == ACTION_LOSS) begin
            ssthresh_in = loss_thresh;
         end else if (limited_ff) begin
            if (slow_ff) begin
               cwnd_in      = ss_cwnd;
               ack_count_in = remainder;
            end else if (ack_count_ff >= cwnd_ff) begin
               if (cwnd_ext < clamp_ext) cwnd_in = cwnd_ff + W'(1);
               ack_count_in = '0;
            end else begin
               ack_count_in = ack_count_ff + W'(1);
            end
         end
      end
   end

   // Load the result register, hold it while stalled
   assign cwnd_out_ext     = AW'(cwnd_in);
   assign ssthresh_out_ext = AW'(ssthresh_in);
   always_comb begin
      rsp_window_in    = rsp_window_ff;
      rsp_threshold_in = rsp_threshold_ff;
      rsp_limited_in   = rsp_limited_ff;
      rsp_floor_in     = rsp_floor_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in     = 1'b1;
         rsp_window_in    = cwnd_out_ext[FIELD_W-1:0];
         rsp_threshold_in = ssthresh_out_ext[FIELD_W-1:0];
         rsp_limited_in   = (action_ff == ACTION_ACK) && limited_ff;
         rsp_floor_in     = ssthresh_out_ext[FIELD_W-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_limit_ff          <= SS_LIMIT_RESET;
         tso_win_divisor_ff   <= TSO_WIN_DIVISOR_RESET;
         gso_enabled_ff       <= GSO_ENABLED_RESET;
         gso_max_size_ff      <= GSO_MAX_SIZE_RESET;
         gso_max_segs_ff      <= GSO_MAX_SEGS_RESET;
         segment_size_ff      <= SEGMENT_SIZE_RESET;
         window_clamp_ff      <= WINDOW_CLAMP_RESET;
         deferred_segments_ff <= DEFERRED_SEGMENTS_RESET;
         cwnd_ff              <= W'(INIT_WINDOW);
         ssthresh_ff          <= '1;
         ack_count_ff         <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         ss_limit_ff          <= ss_limit_in;
         tso_win_divisor_ff   <= tso_win_divisor_in;
         gso_enabled_ff       <= gso_enabled_in;
         gso_max_size_ff      <= gso_max_size_in;
         gso_max_segs_ff      <= gso_max_segs_in;
         segment_size_ff      <= segment_size_in;
         window_clamp_ff      <= window_clamp_in;
         deferred_segments_ff <= deferred_segments_in;
         cwnd_ff              <= cwnd_in;
         ssthresh_ff          <= ssthresh_in;
         ack_count_ff         <= ack_count_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff        <= action_in;
      flight_ge_ff     <= flight_ge_in;
      left_ff          <= left_in;
      tso_prod_ff      <= tso_prod_in;
      seg_prod_ff      <= seg_prod_in;
      limited_ff       <= limited_in;
      slow_ff          <= slow_in;
      rsp_window_ff    <= rsp_window_in;
      rsp_threshold_ff <= rsp_threshold_in;
      rsp_limited_ff   <= rsp_limited_in;
      rsp_floor_ff     <= rsp_floor_in;
   end

   // Status to the controller
   assign status.is_loss    = (action_ff == ACTION_LOSS);
   assign status.limited    = limited_now;
   assign status.exp_growth = slow_now;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window         = rsp_window_ff;
   assign rsp_threshold      = rsp_threshold_ff;
   assign rsp_window_limited = rsp_limited_ff;
   assign rsp_floor_window   = rsp_floor_ff;

endmodule

FILE: tb/reno_window_checker.sv
module reno_window_checker import rcwu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_action,
   input  logic [FIELD_W-1:0]     req_packets_in_flight,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [FIELD_W-1:0]     rsp_window,
   input  logic [FIELD_W-1:0]     rsp_threshold,
   input  logic                   rsp_window_limited,
   input  logic [FLOOR_W-1:0]     rsp_floor_window,
   output int                     failures,
   output int                     pending,
   output logic [FIELD_W-1:0]     window_hint
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [FIELD_W-1:0] window;
      logic [FIELD_W-1:0] threshold;
      logic               limited;
      logic [FLOOR_W-1:0] floor_window;
   } window_report_type;

   window_report_type expected_reports[$];
   int                failure_count;

   // Connection state as the block should hold it
   logic [FIELD_W-1:0] cwnd_q;
   logic [FIELD_W-1:0] ssthresh_q;
   logic [FIELD_W-1:0] ack_count_q;

   // Register copies
   logic [FIELD_W-1:0]    ss_limit_q;
   logic [TSO_DIV_W-1:0]  tso_divisor_q;
   logic                  gso_enabled_q;
   logic [GSO_SIZE_W-1:0] gso_max_size_q;
   logic [FIELD_W-1:0]    gso_max_segs_q;
   logic [FIELD_W-1:0]    segment_size_q;
   logic [FIELD_W-1:0]    clamp_q;
   logic [DEFER_W-1:0]    deferred_q;

   // Apply one event to the connection state and report the outcome
   function automatic window_report_type predict_report(logic action,
                                                        logic [FIELD_W-1:0] flight);
      window_report_type  report;
      logic               limited;
      logic [FIELD_W-1:0] left;
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] increment;
      logic [FIELD_W-1:0] half;
      logic [31:0]        tso_span;
      logic [31:0]        gso_bytes;
      logic [FIELD_W:0]   total;
      logic [FIELD_W:0]   grown;
      limited = 1'b0;
      if (action == ACTION_ACK) begin
         // Window is the limit when full, or when the free part may be deferred
         if (flight >= cwnd_q) begin
            limited = 1'b1;
         end else begin
            left      = cwnd_q - flight;
            tso_span  = 32'(left) * 32'(tso_divisor_q);
            gso_bytes = 32'(left) * 32'(segment_size_q);
            limited   = (gso_enabled_q && tso_span < 32'(cwnd_q) &&
                         gso_bytes < 32'(gso_max_size_q) && left < gso_max_segs_q) ||
                        (left <= FIELD_W'(deferred_q));
         end
         if (limited && cwnd_q <= ssthresh_q) begin
            // Slow start: a zero window counts as one, except against the limit
            base = (cwnd_q == '0) ? FIELD_W'(1) : cwnd_q;
            if (ss_limit_q != '0 && cwnd_q > ss_limit_q)
               increment = ss_limit_q >> 1;
            else
               increment = base;
            total       = {1'b0, ack_count_q} + {1'b0, increment};
            grown       = {1'b0, base} + total / {1'b0, base};
            ack_count_q = FIELD_W'(total % {1'b0, base});
            cwnd_q      = (grown < {1'b0, clamp_q}) ? grown[FIELD_W-1:0] : clamp_q;
         end else if (limited) begin
            // Additive increase: one packet per window's worth of acks
            if (ack_count_q >= cwnd_q) begin
               if (cwnd_q < clamp_q)
                  cwnd_q = cwnd_q + FIELD_W'(1);
               ack_count_q = '0;
            end else begin
               ack_count_q = ack_count_q + FIELD_W'(1);
            end
         end
      end else begin
         // Loss: halve into ssthresh, never below the minimum
         half       = cwnd_q >> 1;
         ssthresh_q = (half > FIELD_W'(MIN_THRESHOLD)) ? half : FIELD_W'(MIN_THRESHOLD);
      end
      report.window       = cwnd_q;
      report.threshold    = ssthresh_q;
      report.limited      = limited;
      report.floor_window = ssthresh_q[FIELD_W-1:1];
      return report;
   endfunction

   task automatic check_field(input string field, input int unsigned want_value,
                              input int unsigned got_value);
      if (want_value != got_value) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field, want_value, got_value);
         failure_count++;
      end
   endtask

   always @(posedge clock) begin
      window_report_type want;
      if (reset) begin
         // Return state and registers to their reset values
         cwnd_q         = FIELD_W'(INIT_WINDOW_DEFAULT);
         ssthresh_q     = '1;
         ack_count_q    = '0;
         ss_limit_q     = SS_LIMIT_RESET;
         tso_divisor_q  = TSO_WIN_DIVISOR_RESET;
         gso_enabled_q  = GSO_ENABLED_RESET;
         gso_max_size_q = GSO_MAX_SIZE_RESET;
         gso_max_segs_q = GSO_MAX_SEGS_RESET;
         segment_size_q = SEGMENT_SIZE_RESET;
         clamp_q        = WINDOW_CLAMP_RESET;
         deferred_q     = DEFERRED_SEGMENTS_RESET;
         expected_reports.delete();
      end else begin
         // Compare each accepted response with the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %0d %0d %0d %0d",
                        $time, rsp_window, rsp_threshold, rsp_window_limited,
                        rsp_floor_window);
               failure_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("window", 32'(want.window), 32'(rsp_window));
               check_field("threshold", 32'(want.threshold), 32'(rsp_threshold));
               check_field("window_limited", 32'(want.limited), 32'(rsp_window_limited));
               check_field("floor_window", 32'(want.floor_window), 32'(rsp_floor_window));
            end
         end
         // Track register writes; unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SS_LIMIT:          ss_limit_q     = csr_wdata[FIELD_W-1:0];
               CSR_TSO_WIN_DIVISOR:   tso_divisor_q  = csr_wdata[TSO_DIV_W-1:0];
               CSR_GSO_ENABLED:       gso_enabled_q  = csr_wdata[0];
               CSR_GSO_MAX_SIZE:      gso_max_size_q = csr_wdata[GSO_SIZE_W-1:0];
               CSR_GSO_MAX_SEGS:      gso_max_segs_q = csr_wdata[FIELD_W-1:0];
               CSR_SEGMENT_SIZE:      segment_size_q = csr_wdata[FIELD_W-1:0];
               CSR_WINDOW_CLAMP:      clamp_q        = csr_wdata[FIELD_W-1:0];
               CSR_DEFERRED_SEGMENTS: deferred_q     = csr_wdata[DEFER_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_reports.push_back(predict_report(req_action, req_packets_in_flight));
      end
      failures    <= failure_count;
      pending     <= expected_reports.size();
      window_hint <= cwnd_q;
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rcwu_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [FIELD_W-1:0] FLIGHT_MAX = '1;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = ACTION_ACK;
   logic [FIELD_W-1:0]     req_packets_in_flight = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FIELD_W-1:0]     rsp_window;
   logic [FIELD_W-1:0]     rsp_threshold;
   logic                   rsp_window_limited;
   logic [FLOOR_W-1:0]     rsp_floor_window;

   int                 failure_count;
   int                 pending_reports;
   logic [FIELD_W-1:0] window_hint;
   logic               rsp_idle_on = 1'b1;
   int                 stall_left = 0;
   int                 cycle_count = 0;

   reno_congestion_window_update_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_packets_in_flight (req_packets_in_flight),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_window            (rsp_window),
      .rsp_threshold         (rsp_threshold),
      .rsp_window_limited    (rsp_window_limited),
      .rsp_floor_window      (rsp_floor_window)
   );

   reno_window_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_packets_in_flight (req_packets_in_flight),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_window            (rsp_window),
      .rsp_threshold         (rsp_threshold),
      .rsp_window_limited    (rsp_window_limited),
      .rsp_floor_window      (rsp_floor_window),
      .failures              (failure_count),
      .pending               (pending_reports),
      .window_hint           (window_hint)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stall responses in random bursts while rsp_idle_on is set
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 6) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one request and hold it until accepted
   task automatic send_request(input logic action, input logic [FIELD_W-1:0] flight);
      req_valid             <= 1'b1;
      req_action            <= action;
      req_packets_in_flight <= flight;
      do @(posedge clock); while (req_stall);
   endtask

   // Present one register write and hold it until accepted
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain every outstanding request, then let the engine settle
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reports != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pick a register value: range ends half of the time
   function automatic logic [CSR_DATA_W-1:0] pick_setting(input logic [CSR_INDEX_W-1:0] index);
      int unsigned low;
      int unsigned high;
      case (index)
         CSR_GSO_ENABLED:                            high = 1;
         CSR_TSO_WIN_DIVISOR, CSR_DEFERRED_SEGMENTS: high = 255;
         CSR_GSO_MAX_SIZE:                           high = 65536;
         default:                                    high = 65535;
      endcase
      low = (index == CSR_SEGMENT_SIZE || index == CSR_WINDOW_CLAMP) ? 1 : 0;
      case ($urandom_range(0, 3))
         0:       return CSR_DATA_W'(low);
         1:       return CSR_DATA_W'(high);
         default: return CSR_DATA_W'($urandom_range(low, high));
      endcase
   endfunction

   // Aim the in-flight count around the current window
   function automatic logic [FIELD_W-1:0] pick_flight();
      int unsigned hint;
      int unsigned offset;
      hint   = 32'(window_hint);
      offset = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
         0, 1, 2:    return (hint + offset > 32'(FLIGHT_MAX)) ? FLIGHT_MAX
                                                               : FIELD_W'(hint + offset);
         3, 4, 5, 6: begin
            offset = $urandom_range(0, 12);
            return (offset > hint) ? '0 : FIELD_W'(hint - offset);
         end
         7:          return FIELD_W'($urandom_range(0, hint));
         8:          return FIELD_W'($urandom);
         default:    return $urandom_range(0, 1) ? FLIGHT_MAX : '0;
      endcase
   endfunction

   // Rewrite every register, plus one write to an unused index
   task automatic randomize_settings();
      for (int i = int'(CSR_SS_LIMIT); i <= int'(CSR_DEFERRED_SEGMENTS); i++)
         csr_write(CSR_INDEX_W'(i), pick_setting(CSR_INDEX_W'(i)));
      csr_write(CSR_INDEX_W'(CSR_DEFERRED_SEGMENTS + 1 + $urandom_range(0, 7)),
                CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Stream random requests, with losses only when asked
   task automatic random_traffic(input int count, input bit with_loss, input bit idle_on);
      logic action;
      rsp_idle_on <= idle_on;
      for (int n = 0; n < count; n++) begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         action = (with_loss && $urandom_range(0, 9) == 0) ? ACTION_LOSS : ACTION_ACK;
         send_request(action, pick_flight());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: idle window, offload deferral, full window
      send_request(ACTION_ACK, '0);
      send_request(ACTION_ACK, 16'd8);
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_ACK, 16'd12);
      send_request(ACTION_ACK, 16'd9);

      // Limited slow start into a zero clamp, then slow start from a zero window
      wait_for_idle();
      csr_write(CSR_SS_LIMIT, 17'd4);
      csr_write(CSR_WINDOW_CLAMP, 17'd0);
      csr_write(CSR_GSO_ENABLED, 17'd0);
      csr_valid <= 1'b0;
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_ACK, '0);

      // Regrow from zero with offload off and no deferral allowance
      wait_for_idle();
      csr_write(CSR_WINDOW_CLAMP, 17'd65535);
      csr_write(CSR_SS_LIMIT, 17'd0);
      csr_write(CSR_DEFERRED_SEGMENTS, 17'd0);
      csr_valid <= 1'b0;
      send_request(ACTION_ACK, '0);
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_ACK, 16'd1);

      // Widest deferral allowance
      wait_for_idle();
      csr_write(CSR_DEFERRED_SEGMENTS, 17'd255);
      csr_valid <= 1'b0;
      send_request(ACTION_ACK, 16'd1);

      // Slow start only: no loss yet, so ssthresh stays wide open
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_idle();
         randomize_settings();
         random_traffic(200, 1'b0, phase != 2);
      end

      // Pull the window down to one, then lose at the floor of the threshold
      wait_for_idle();
      csr_write(CSR_WINDOW_CLAMP, 17'd1);
      csr_valid <= 1'b0;
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_LOSS, '0);

      // Finish slow start into additive increase, and lose again
      wait_for_idle();
      csr_write(CSR_WINDOW_CLAMP, 17'd65535);
      csr_valid <= 1'b0;
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_ACK, FLIGHT_MAX);
      send_request(ACTION_LOSS, FLIGHT_MAX);

      // Additive increase with the window above the clamp
      wait_for_idle();
      csr_write(CSR_WINDOW_CLAMP, 17'd1);
      csr_valid <= 1'b0;
      repeat (5) send_request(ACTION_ACK, FLIGHT_MAX);

      // Additive increase mixed with losses; quiet handshakes at the end
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_idle();
         randomize_settings();
         random_traffic(250, 1'b1, phase == 0 || phase == 2);
      end

      wait_for_idle();
      if (failure_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
